FILE: src/cam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera basis package
// Shared types and constants for the yaw/pitch camera basis unit.
// ----------------------------------------------------------------------------
package cam_pkg;

    // Command codes carried on the op field.
    localparam logic [1:0] OP_SET_ANG = 2'd0;
    localparam logic [1:0] OP_ROT_ANG = 2'd1;
    localparam logic [1:0] OP_MOVE    = 2'd2;
    localparam logic [1:0] OP_SET_POS = 2'd3;

    localparam int TWO_PI_Q12  = 25736;
    localparam int HALF_PI_Q12 = 6434;
    localparam int TWO_PI_F    = 6588397;
    localparam int PI_F        = 3294199;
    localparam int HALF_PI_F   = 1647099;
    localparam int CORDIC_GAIN = 652032874;
    localparam int UNIT_Q14    = 16384;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORDIC,
        ST_STORE,
        ST_MUL,
        ST_MOVE,
        ST_OUT
    } cam_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic       load;      // capture the input transaction
        logic       prep;      // wrap angles and reduce the CORDIC argument
        logic       step;      // one CORDIC iteration
        logic       store;     // store CORDIC result for the current angle
        logic       mul;       // one product step
        logic       move;      // one translate step
        logic       finish;    // copy results into the output registers
        logic [3:0] cnt;       // iteration counter
        logic       sel;       // 0 yaw, 1 pitch
    } cam_cmd_t;

    // CORDIC arctangent table at 2^20 scale.
    function automatic logic signed [31:0] atan_tab(input logic [3:0] i);
        case (i)
            4'd0:    atan_tab = 32'sd823550;
            4'd1:    atan_tab = 32'sd486170;
            4'd2:    atan_tab = 32'sd256879;
            4'd3:    atan_tab = 32'sd130396;
            4'd4:    atan_tab = 32'sd65451;
            4'd5:    atan_tab = 32'sd32757;
            4'd6:    atan_tab = 32'sd16383;
            4'd7:    atan_tab = 32'sd8192;
            4'd8:    atan_tab = 32'sd4096;
            4'd9:    atan_tab = 32'sd2048;
            4'd10:   atan_tab = 32'sd1024;
            4'd11:   atan_tab = 32'sd512;
            4'd12:   atan_tab = 32'sd256;
            4'd13:   atan_tab = 32'sd128;
            4'd14:   atan_tab = 32'sd64;
            default: atan_tab = 32'sd32;
        endcase
    endfunction

    // Clamp to the closed unit range of Q2.14.
    function automatic logic signed [15:0] clamp_unit(input logic signed [47:0] v);
        if (v > 48'sd16384)
            clamp_unit = 16'sd16384;
        else if (v < -48'sd16384)
            clamp_unit = -16'sd16384;
        else
            clamp_unit = v[15:0];
    endfunction

endpackage

FILE: src/cam_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera basis controller
// Sequences the angle update, the CORDIC passes, the products and the moves.
// ----------------------------------------------------------------------------
module cam_ctrl
    import cam_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    output logic       m_valid,
    input  logic       m_ready,
    output cam_cmd_t   cmd
);

    cam_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;
    logic       mv_reg, mv_next;
    logic       busy;

    // A finished result may wait in the output register while a new one is worked.
    assign busy    = state_reg != ST_IDLE;
    assign s_ready = !busy;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cnt_next = '0;
                    sel_next = 1'b0;
                    if (s_op == OP_SET_ANG || s_op == OP_ROT_ANG)
                        state_next = ST_PREP;
                    else if (s_op == OP_MOVE)
                        state_next = ST_MOVE;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_PREP: begin
                cnt_next   = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_STORE;
            end
            ST_STORE: begin
                cnt_next = '0;
                if (sel_reg) begin
                    state_next = ST_MUL;
                end else begin
                    sel_next   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_MUL: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3)
                    state_next = ST_OUT;
            end
            ST_MOVE: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd9)
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid tracking.
    always_comb begin
        mv_next = mv_reg;
        if (m_ready)
            mv_next = 1'b0;
        if (state_reg == ST_OUT && (!mv_reg || m_ready))
            mv_next = 1'b1;
    end

    // Command outputs.
    always_comb begin
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        cmd.sel    = sel_reg;
        cmd.load   = s_valid && s_ready;
        cmd.prep   = state_reg == ST_PREP;
        cmd.step   = state_reg == ST_CORDIC;
        cmd.store  = state_reg == ST_STORE;
        cmd.mul    = state_reg == ST_MUL;
        cmd.move   = state_reg == ST_MOVE;
        cmd.finish = state_reg == ST_OUT && (!mv_reg || m_ready);
    end

    assign m_valid = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            mv_reg    <= mv_next;
        end
    end

    // A result is only raised from the output state.
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");
    // No input is taken while an item is in work.
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready)
        else $error("input accepted while busy");
    // CORDIC pass always ends in the store state.
    a_cordic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC && cnt_reg == 4'd15) |=> state_reg == ST_STORE)
        else $error("CORDIC pass did not end");

endmodule

FILE: src/cam_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera basis datapath
// Angle state, shared CORDIC, shared multiplier, basis and position registers.
// ----------------------------------------------------------------------------
module cam_dp
    import cam_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cam_cmd_t           cmd,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_angle_yaw,
    input  logic signed [15:0] s_angle_pitch,
    input  logic signed [31:0] s_vec_x,
    input  logic signed [31:0] s_vec_y,
    input  logic signed [31:0] s_vec_z,
    output logic signed [15:0] m_fwd_x,
    output logic signed [15:0] m_fwd_y,
    output logic signed [15:0] m_fwd_z,
    output logic signed [15:0] m_up_x,
    output logic signed [15:0] m_up_y,
    output logic signed [15:0] m_up_z,
    output logic signed [15:0] m_right_x,
    output logic signed [15:0] m_right_y,
    output logic signed [15:0] m_right_z,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z
);

    logic signed [15:0] yaw_reg, pitch_reg;
    logic signed [15:0] fwd_reg [3], up_reg [3], rgt_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vin_reg [3];
    logic signed [17:0] ny_reg, np_reg;
    logic [1:0]         op_reg;

    // CORDIC registers.
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [24:0] ca_reg;
    logic               flip_reg;
    logic signed [31:0] cyaw_reg, syaw_reg, cpit_reg, spit_reg;

    // Multiplier result and translate accumulator.
    logic signed [63:0] prod_reg;
    logic signed [49:0] acc_reg;

    // ---- angle wrap and clamp ----
    logic signed [17:0] ny_w, ny_s, np_c;
    always_comb begin
        ny_w = ny_reg;
        if (ny_reg > 18'sd25736)
            ny_w = ny_reg - 18'sd25736;
        else if (ny_reg < -18'sd25736)
            ny_w = ny_reg + 18'sd25736;
        ny_s = ny_w;
        if (ny_w > 18'sd32767)
            ny_s = 18'sd32767;
        else if (ny_w < -18'sd32768)
            ny_s = -18'sd32768;
        np_c = np_reg;
        if (np_reg > 18'sd6434)
            np_c = 18'sd6434;
        else if (np_reg < -18'sd6434)
            np_c = -18'sd6434;
    end

    // ---- CORDIC argument reduction ----
    logic signed [15:0] ang_sel;
    logic signed [24:0] a0, a1, a2;
    logic               flip_w;
    always_comb begin
        ang_sel = cmd.sel ? np_c[15:0] : ny_s[15:0];
        a0 = {{1{ang_sel[15]}}, ang_sel, 8'd0};
        a1 = a0;
        if (a0 > 25'sd3294199)
            a1 = a0 - 25'sd6588397;
        else if (a0 < -25'sd3294199)
            a1 = a0 + 25'sd6588397;
        a2 = a1;
        flip_w = 1'b0;
        if (a1 > 25'sd1647099) begin
            a2 = a1 - 25'sd3294199;
            flip_w = 1'b1;
        end else if (a1 < -25'sd1647099) begin
            a2 = a1 + 25'sd3294199;
            flip_w = 1'b1;
        end
    end

    // ---- CORDIC iteration ----
    logic signed [31:0] dx, dy;
    logic signed [31:0] at;
    assign dx = cy_reg >>> cmd.cnt;
    assign dy = cx_reg >>> cmd.cnt;
    assign at = atan_tab(cmd.cnt);

    // ---- shared multiplier operand selection ----
    logic signed [31:0] ma, mb;
    always_comb begin
        ma = '0;
        mb = '0;
        if (cmd.mul) begin
            case (cmd.cnt[1:0])
                2'd0:    begin ma = cpit_reg;  mb = syaw_reg; end
                2'd1:    begin ma = cpit_reg;  mb = cyaw_reg; end
                2'd2:    begin ma = -spit_reg; mb = syaw_reg; end
                default: begin ma = -spit_reg; mb = cyaw_reg; end
            endcase
        end else begin
            // Translate: step = 3*k + j, k coordinate, j axis; cnt 0..8 multiply.
            case (cmd.cnt)
                4'd0:    begin ma = 32'(rgt_reg[0]); mb = vin_reg[0]; end
                4'd1:    begin ma = 32'(up_reg[0]);  mb = vin_reg[1]; end
                4'd2:    begin ma = 32'(fwd_reg[0]); mb = vin_reg[2]; end
                4'd3:    begin ma = 32'(rgt_reg[1]); mb = vin_reg[0]; end
                4'd4:    begin ma = 32'(up_reg[1]);  mb = vin_reg[1]; end
                4'd5:    begin ma = 32'(fwd_reg[1]); mb = vin_reg[2]; end
                4'd6:    begin ma = 32'(rgt_reg[2]); mb = vin_reg[0]; end
                4'd7:    begin ma = 32'(up_reg[2]);  mb = vin_reg[1]; end
                default: begin ma = 32'(fwd_reg[2]); mb = vin_reg[2]; end
            endcase
        end
    end

    // Rounded basis product from the previous multiply.
    logic signed [15:0] prod_q;
    logic signed [63:0] prod_r;
    assign prod_r = (prod_reg + 64'sd35184372088832) >>> 46;
    assign prod_q = clamp_unit(prod_r[47:0]);

    // Position accumulate: the product of step cnt-1 lands here, and mk is
    // the coordinate that product belongs to.
    logic [1:0]         mk;
    logic signed [49:0] acc_add;
    logic signed [49:0] s_r;
    logic signed [50:0] psum;
    logic signed [31:0] psat;
    logic               last_of_k;
    always_comb begin
        mk = 2'd0;
        if (cmd.cnt > 4'd6)
            mk = 2'd2;
        else if (cmd.cnt > 4'd3)
            mk = 2'd1;
        last_of_k = cmd.cnt == 4'd3 || cmd.cnt == 4'd6 || cmd.cnt == 4'd9;
        acc_add = acc_reg + 50'(prod_reg);
        s_r  = (acc_add + 50'sd8192) >>> 14;
        psum = 51'(pos_reg[mk]) + 51'(s_r);
        if (psum > 51'sd2147483647)
            psat = 32'h7fffffff;
        else if (psum < -51'sd2147483648)
            psat = 32'h80000000;
        else
            psat = psum[31:0];
    end

    // Rounded single CORDIC component.
    function automatic logic signed [15:0] one30(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = (33'(v) + 33'sd32768) >>> 16;
        one30 = clamp_unit(48'(t));
    endfunction

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
            fwd_reg   <= '{16'sd0, 16'sd0, 16'sd16384};
            up_reg    <= '{16'sd0, 16'sd16384, 16'sd0};
            rgt_reg   <= '{16'sd16384, 16'sd0, 16'sd0};
            pos_reg   <= '{32'sd0, 32'sd0, 32'sd0};
        end else begin
            if (cmd.load) begin
                op_reg <= s_op;
                vin_reg <= '{s_vec_x, s_vec_y, s_vec_z};
                if (s_op == OP_ROT_ANG) begin
                    ny_reg <= 18'(yaw_reg) + 18'(s_angle_yaw);
                    np_reg <= 18'(pitch_reg) + 18'(s_angle_pitch);
                end else begin
                    ny_reg <= 18'(s_angle_yaw);
                    np_reg <= 18'(s_angle_pitch);
                end
                if (s_op == OP_SET_POS)
                    pos_reg <= '{s_vec_x, s_vec_y, s_vec_z};
                acc_reg <= '0;
            end
            if (cmd.prep) begin
                cx_reg   <= 32'sd652032874;
                cy_reg   <= '0;
                ca_reg   <= a2;
                flip_reg <= flip_w;
                yaw_reg   <= ny_s[15:0];
                pitch_reg <= np_c[15:0];
            end
            if (cmd.step) begin
                if (!ca_reg[24]) begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    ca_reg <= ca_reg - at[24:0];
                end else begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    ca_reg <= ca_reg + at[24:0];
                end
            end
            if (cmd.store) begin
                if (cmd.sel) begin
                    cpit_reg <= flip_reg ? -cx_reg : cx_reg;
                    spit_reg <= flip_reg ? -cy_reg : cy_reg;
                end else begin
                    cyaw_reg <= flip_reg ? -cx_reg : cx_reg;
                    syaw_reg <= flip_reg ? -cy_reg : cy_reg;
                end
            end
            if (cmd.mul || cmd.move)
                prod_reg <= ma * mb;
            // Each product is registered in prod_reg and written to the basis from there.
            if (cmd.mul) begin
                case (cmd.cnt[1:0])
                    2'd1: fwd_reg[0] <= prod_q;
                    2'd2: fwd_reg[2] <= prod_q;
                    2'd3: up_reg[0]  <= prod_q;
                    default: begin
                        fwd_reg[1] <= one30(spit_reg);
                        up_reg[1]  <= one30(cpit_reg);
                        rgt_reg[0] <= one30(cyaw_reg);
                        rgt_reg[1] <= '0;
                        rgt_reg[2] <= one30(-syaw_reg);
                    end
                endcase
            end
            if (cmd.finish && op_reg != OP_MOVE && op_reg != OP_SET_POS
                    && cmd.cnt == 4'd4)
                up_reg[2] <= prod_q;
            if (cmd.move && cmd.cnt != 4'd0) begin
                if (last_of_k) begin
                    pos_reg[mk] <= psat;
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_add;
                end
            end
        end
    end

    // Output registers, loaded when the controller finishes a result.
    logic signed [15:0] of_reg [9];
    logic signed [31:0] op_pos_reg [3];
    logic signed [15:0] up_z_w;
    assign up_z_w = (op_reg != OP_MOVE && op_reg != OP_SET_POS && cmd.cnt == 4'd4)
                    ? prod_q : up_reg[2];
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            of_reg <= '{fwd_reg[0], fwd_reg[1], fwd_reg[2], up_reg[0], up_reg[1],
                        up_z_w, rgt_reg[0], rgt_reg[1], rgt_reg[2]};
            op_pos_reg <= pos_reg;
        end
    end

    assign m_fwd_x   = of_reg[0];
    assign m_fwd_y   = of_reg[1];
    assign m_fwd_z   = of_reg[2];
    assign m_up_x    = of_reg[3];
    assign m_up_y    = of_reg[4];
    assign m_up_z    = of_reg[5];
    assign m_right_x = of_reg[6];
    assign m_right_y = of_reg[7];
    assign m_right_z = of_reg[8];
    assign m_pos_x   = op_pos_reg[0];
    assign m_pos_y   = op_pos_reg[1];
    assign m_pos_z   = op_pos_reg[2];

    // Stored pitch never leaves its clamp range.
    a_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        pitch_reg <= 16'sd6434 && pitch_reg >= -16'sd6434)
        else $error("pitch out of range");
    // Right vector has no vertical component.
    a_right_y: assert property (@(posedge aclk) disable iff (!aresetn)
        rgt_reg[1] == 16'sd0)
        else $error("right vector tilted");
    // A CORDIC start always loads the gain.
    a_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.prep |=> cx_reg == 32'sd652032874 && cy_reg == 32'sd0)
        else $error("CORDIC start wrong");

endmodule

FILE: src/camera_yaw_pitch_basis_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera yaw/pitch basis unit
// First-person camera: angles, orthonormal basis and saturated position.
// ----------------------------------------------------------------------------
// Each transaction returns one result. Translate runs nine products through
// one shared 32x32 multiplier, and angle commands run two 16-step CORDIC
// passes on one shared CORDIC unit, then four basis products on the
// multiplier. A new transaction is taken once the previous result has been
// handed over or is waiting in the output register.
module camera_yaw_pitch_basis_unit
    import cam_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_angle_yaw,
    input  logic signed [15:0] s_angle_pitch,
    input  logic signed [31:0] s_vec_x,
    input  logic signed [31:0] s_vec_y,
    input  logic signed [31:0] s_vec_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_fwd_x,
    output logic signed [15:0] m_fwd_y,
    output logic signed [15:0] m_fwd_z,
    output logic signed [15:0] m_up_x,
    output logic signed [15:0] m_up_y,
    output logic signed [15:0] m_up_z,
    output logic signed [15:0] m_right_x,
    output logic signed [15:0] m_right_y,
    output logic signed [15:0] m_right_z,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z
);

    cam_cmd_t cmd;

    // Sequencer.
    cam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Arithmetic and state.
    cam_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_op          (s_op),
        .s_angle_yaw   (s_angle_yaw),
        .s_angle_pitch (s_angle_pitch),
        .s_vec_x       (s_vec_x),
        .s_vec_y       (s_vec_y),
        .s_vec_z       (s_vec_z),
        .m_fwd_x       (m_fwd_x),
        .m_fwd_y       (m_fwd_y),
        .m_fwd_z       (m_fwd_z),
        .m_up_x        (m_up_x),
        .m_up_y        (m_up_y),
        .m_up_z        (m_up_z),
        .m_right_x     (m_right_x),
        .m_right_y     (m_right_y),
        .m_right_z     (m_right_z),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_pos_z       (m_pos_z)
    );

endmodule

FILE: tb/sv/camera_basis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera basis checker
// Watches both channels of the camera basis unit, predicts each result from
// its own copy of the angles, basis and position, and compares field by field.
// ----------------------------------------------------------------------------
module camera_basis_checker
    import cam_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_angle_yaw,
    input  logic signed [15:0] s_angle_pitch,
    input  logic signed [31:0] s_vec_x,
    input  logic signed [31:0] s_vec_y,
    input  logic signed [31:0] s_vec_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_fwd_x,
    input  logic signed [15:0] m_fwd_y,
    input  logic signed [15:0] m_fwd_z,
    input  logic signed [15:0] m_up_x,
    input  logic signed [15:0] m_up_y,
    input  logic signed [15:0] m_up_z,
    input  logic signed [15:0] m_right_x,
    input  logic signed [15:0] m_right_y,
    input  logic signed [15:0] m_right_z,
    input  logic signed [31:0] m_pos_x,
    input  logic signed [31:0] m_pos_y,
    input  logic signed [31:0] m_pos_z,
    output int                 fail_count,
    output int                 pending_count
);

    // One camera result: forward, up, right (Q2.14) and position (Q16.16).
    typedef struct packed {
        logic signed [2:0][15:0] fwd;
        logic signed [2:0][15:0] up;
        logic signed [2:0][15:0] rgt;
        logic signed [2:0][31:0] pos;
    } cam_view_t;

    cam_view_t        view_queue[$];
    logic signed [15:0] cam_yaw, cam_pitch;
    logic signed [15:0] cam_fwd[3], cam_up[3], cam_rgt[3];
    logic signed [31:0] cam_pos[3];

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] to_unit(longint v);
        if (v > UNIT_Q14) return 16'sd16384;
        if (v < -UNIT_Q14) return -16'sd16384;
        return v[15:0];
    endfunction

    // CORDIC sine and cosine at 2^30 scale, bit-exact with the hardware.
    task automatic sin_cos(input logic signed [15:0] ang, output longint c,
                           output longint s);
        longint a, x, y, dx, dy;
        longint atans[16];
        bit flip;
        atans = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                  4096, 2048, 1024, 512, 256, 128, 64, 32};
        a = longint'(ang) * 256;
        x = CORDIC_GAIN;
        y = 0;
        flip = 0;
        while (a > PI_F) a -= TWO_PI_F;
        while (a < -PI_F) a += TWO_PI_F;
        if (a > HALF_PI_F) begin
            a -= PI_F;
            flip = 1;
        end else if (a < -HALF_PI_F) begin
            a += PI_F;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                x -= dx; y += dy; a -= atans[i];
            end else begin
                x += dx; y -= dy; a += atans[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic signed [15:0] single(longint v);
        return to_unit((v + (64'sd1 <<< 15)) >>> 16);
    endfunction

    function automatic logic signed [15:0] product(longint a, longint b);
        return to_unit((a * b + (64'sd1 <<< 45)) >>> 46);
    endfunction

    // Wrap yaw once, clamp pitch, then rebuild the basis.
    task automatic aim_camera(input longint ny, input longint np);
        longint cy, sy, cp, sp;
        if (ny > TWO_PI_Q12) ny -= TWO_PI_Q12;
        else if (ny < -TWO_PI_Q12) ny += TWO_PI_Q12;
        if (ny > 32767) ny = 32767;
        if (ny < -32768) ny = -32768;
        if (np > HALF_PI_Q12) np = HALF_PI_Q12;
        else if (np < -HALF_PI_Q12) np = -HALF_PI_Q12;
        cam_yaw = ny[15:0];
        cam_pitch = np[15:0];
        sin_cos(cam_yaw, cy, sy);
        sin_cos(cam_pitch, cp, sp);
        cam_fwd[0] = product(cp, sy);
        cam_fwd[1] = single(sp);
        cam_fwd[2] = product(cp, cy);
        cam_rgt[0] = single(cy);
        cam_rgt[1] = 0;
        cam_rgt[2] = single(-sy);
        cam_up[0] = product(-sp, sy);
        cam_up[1] = single(cp);
        cam_up[2] = product(-sp, cy);
    endtask

    // Apply one command and queue the resulting view.
    task automatic predict_view(input logic [1:0] op, input logic signed [15:0] ay,
                                input logic signed [15:0] ap,
                                input logic signed [31:0] v0,
                                input logic signed [31:0] v1,
                                input logic signed [31:0] v2);
        longint sum, np;
        cam_view_t res;
        case (op)
            OP_SET_ANG: aim_camera(ay, ap);
            OP_ROT_ANG: aim_camera(longint'(cam_yaw) + ay, longint'(cam_pitch) + ap);
            OP_MOVE: begin
                for (int k = 0; k < 3; k++) begin
                    sum = longint'(cam_rgt[k]) * v0 + longint'(cam_up[k]) * v1
                        + longint'(cam_fwd[k]) * v2;
                    sum = (sum + (64'sd1 <<< 13)) >>> 14;
                    np = longint'(cam_pos[k]) + sum;
                    if (np > 64'sd2147483647) np = 64'sd2147483647;
                    if (np < -64'sd2147483648) np = -64'sd2147483648;
                    cam_pos[k] = np[31:0];
                end
            end
            default: begin
                cam_pos[0] = v0; cam_pos[1] = v1; cam_pos[2] = v2;
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            res.fwd[k] = cam_fwd[k];
            res.up[k]  = cam_up[k];
            res.rgt[k] = cam_rgt[k];
            res.pos[k] = cam_pos[k];
        end
        view_queue.push_back(res);
    endtask

    assign pending_count = view_queue.size();

    // Predict on input transactions, compare on output transactions.
    always @(posedge aclk) begin
        cam_view_t got, want;
        if (!aresetn) begin
            view_queue.delete();
            fail_count <= 0;
            cam_yaw = 0;
            cam_pitch = 0;
            for (int k = 0; k < 3; k++) begin
                cam_fwd[k] = 0; cam_up[k] = 0; cam_rgt[k] = 0; cam_pos[k] = 0;
            end
            cam_fwd[2] = UNIT_Q14;
            cam_up[1] = UNIT_Q14;
            cam_rgt[0] = UNIT_Q14;
        end else begin
            if (m_valid && m_ready) begin
                got.fwd = {m_fwd_z, m_fwd_y, m_fwd_x};
                got.up  = {m_up_z, m_up_y, m_up_x};
                got.rgt = {m_right_z, m_right_y, m_right_x};
                got.pos = {m_pos_z, m_pos_y, m_pos_x};
                if (view_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("result with nothing expected: %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = view_queue.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_view(s_op, s_angle_yaw, s_angle_pitch, s_vec_x, s_vec_y,
                             s_vec_z);
        end
    end

endmodule

FILE: tb/sv/camera_yaw_pitch_basis_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera yaw/pitch basis unit testbench
// Drives directed and random camera commands with random idling and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module camera_yaw_pitch_basis_unit_tb;
    import cam_pkg::*;

    localparam int NUM_RANDOM  = 1500;
    localparam int CYCLE_LIMIT = 400000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid, s_ready, m_valid, m_ready;
    logic [1:0]         s_op;
    logic signed [15:0] s_angle_yaw, s_angle_pitch;
    logic signed [31:0] s_vec_x, s_vec_y, s_vec_z;
    logic signed [15:0] m_fwd_x, m_fwd_y, m_fwd_z, m_up_x, m_up_y, m_up_z;
    logic signed [15:0] m_right_x, m_right_y, m_right_z;
    logic signed [31:0] m_pos_x, m_pos_y, m_pos_z;
    int                 fail_count, pending_count;
    int                 cycle_count;
    bit                 calm_phase;
    bit                 long_hold;

    camera_yaw_pitch_basis_unit dut (.*);
    camera_basis_checker checker_i (.*);

    // Clock.
    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("camera_yaw_pitch_basis_unit_tb: errors");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none at the end.
    initial begin
        int burst;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready <= 0;
                repeat (300) @(negedge aclk);
                long_hold = 0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 12);
                m_ready <= 0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    // Present one command and hold it until accepted. Valid stays high on
    // return; the caller or the next command drops it.
    task automatic send_cmd(input logic [1:0] op, input logic signed [15:0] ay,
                            input logic signed [15:0] ap, input logic signed [31:0] vx,
                            input logic signed [31:0] vy, input logic signed [31:0] vz);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid <= 1;
        s_op <= op;
        s_angle_yaw <= ay;
        s_angle_pitch <= ap;
        s_vec_x <= vx;
        s_vec_y <= vy;
        s_vec_z <= vz;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 51472) - 25736);
            1: return 16'($urandom_range(0, 13000) - 6500);
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 400) - 200);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_vec();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    // Stimulus.
    initial begin
        logic [1:0] op;
        cycle_count = 0;
        calm_phase = 0;
        long_hold = 0;
        aresetn = 0;
        s_valid = 0;
        s_op = OP_SET_ANG;
        s_angle_yaw = 0;
        s_angle_pitch = 0;
        s_vec_x = 0;
        s_vec_y = 0;
        s_vec_z = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: angle extremes, yaw wrap and saturation, pitch limits, position set and move saturation.
        send_cmd(OP_MOVE, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        send_cmd(OP_SET_ANG, 25736, 6434, 0, 0, 0);
        send_cmd(OP_SET_ANG, -25736, -6434, 0, 0, 0);
        send_cmd(OP_SET_ANG, 25737, 6435, 0, 0, 0);
        send_cmd(OP_SET_ANG, -25737, -6435, 0, 0, 0);
        send_cmd(OP_SET_ANG, 16'sh7fff, 16'sh7fff, 0, 0, 0);
        send_cmd(OP_SET_ANG, 16'sh8000, 16'sh8000, -1, -1, -1);
        send_cmd(OP_SET_ANG, 12868, 0, 0, 0, 0);
        send_cmd(OP_ROT_ANG, 25736, 6434, 0, 0, 0);
        send_cmd(OP_ROT_ANG, 16'sh7fff, 16'sh8000, 0, 0, 0);
        send_cmd(OP_ROT_ANG, -1, 1, 0, 0, 0);
        send_cmd(OP_SET_POS, -1, -1, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_cmd(OP_MOVE, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_cmd(OP_MOVE, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_cmd(OP_SET_ANG, 3000, 6434, 0, 0, 0);
        send_cmd(OP_MOVE, -1, -1, -1, -1, -1);
        send_cmd(OP_SET_POS, 0, 0, -1, 32'sh7fff_ffff, 32'sh8000_0000);
        send_cmd(OP_MOVE, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        s_valid <= 0;

        // Pause until every result is back.
        wait (pending_count == 0);
        @(negedge aclk);

        // Long receiver hold-off while commands keep coming.
        long_hold = 1;
        for (int i = 0; i < 6; i++)
            send_cmd(OP_SET_POS, 0, 0, rand_vec(), rand_vec(), rand_vec());

        // Random commands; the last part without idling.
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM - 150)
                calm_phase = 1;
            op = 2'($urandom_range(0, 3));
            send_cmd(op, rand_angle(), rand_angle(), rand_vec(), rand_vec(),
                     rand_vec());
        end
        s_valid <= 0;

        wait (pending_count == 0);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("camera_yaw_pitch_basis_unit_tb: clean");
        else
            $display("camera_yaw_pitch_basis_unit_tb: errors");
        $finish;
    end

endmodule
